// File: hw/rtl/fme7_pkg.sv
// Shared types and constants for the FME-7 style bank mapper with IRQ counter.
package fme7_pkg;

  localparam int CHR_SLOTS = 8;
  localparam int PRG_SLOTS = 3;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CPU   = 2'd2,
    FUNC_PPU   = 2'd3
  } func_t;

  // Result region codes
  typedef enum logic [2:0] {
    REGION_NONE    = 3'd0,
    REGION_PRG     = 3'd1,
    REGION_RAM_ON  = 3'd2,
    REGION_RAM_OFF = 3'd3,
    REGION_CHR     = 3'd4,
    REGION_NT      = 3'd5
  } region_t;

  // Command latch codes
  localparam logic [3:0] CMD_RAM_CTRL = 4'h8;
  localparam logic [3:0] CMD_PRG0     = 4'h9;
  localparam logic [3:0] CMD_PRG1     = 4'ha;
  localparam logic [3:0] CMD_PRG2     = 4'hb;
  localparam logic [3:0] CMD_MIRROR   = 4'hc;
  localparam logic [3:0] CMD_IRQ_EN   = 4'hd;
  localparam logic [3:0] CMD_CNT_LO   = 4'he;
  localparam logic [3:0] CMD_CNT_HI   = 4'hf;

  // Configuration register indexes
  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

  localparam logic [15:0] IRQ_RELOAD     = 16'hffff;
  localparam logic [7:0]  RAM_CTRL_RESET = 8'h40;
  localparam logic [7:0]  MASK_RESET     = 8'hff;

  // One input item
  typedef struct packed {
    func_t       func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  // Banking state seen by the lookup logic
  typedef struct packed {
    logic [PRG_SLOTS-1:0][7:0] prg_bank;
    logic [CHR_SLOTS-1:0][7:0] chr_bank;
    logic [1:0]                mirror;
    logic [7:0]                ram_control;
  } map_state_t;

endpackage

// File: hw/rtl/fme7_bank_mapper_with_irq_unit.sv
// Top level: input register, mapper state, lookup decode and result register.
// A transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while results are not stalled; the input register and the result
// register give one stage of slack, so input is taken while a result waits.
// Reset (rst, synchronous): both stages empty, banks zero, ram control 0x40,
// IRQ counter 0xFFFF and disarmed, both bank masks 0xFF.
module fme7_bank_mapper_with_irq_unit (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  region,
  output logic [7:0]  bank,
  output logic        irq_line,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                 s1_valid;
  fme7_pkg::item_t      s1_item;
  logic                 s2_load;
  logic                 s1_go;
  logic                 in_take;
  logic [7:0]           prg_mask;
  logic [7:0]           chr_mask;
  fme7_pkg::map_state_t map_state;
  logic                 irq_flag_next;
  fme7_pkg::region_t    region_d;
  logic [7:0]           bank_d;

  // Handshake
  assign s2_load   = !out_valid || !out_stall;
  assign s1_go     = s1_valid && s2_load;
  assign in_stall  = s1_valid && !s2_load;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_mask <= fme7_pkg::MASK_RESET;
      chr_mask <= fme7_pkg::MASK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fme7_pkg::CFG_PRG_MASK: prg_mask <= cfg_data;
        fme7_pkg::CFG_CHR_MASK: chr_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.func       <= fme7_pkg::func_t'(func);
      s1_item.address    <= address;
      s1_item.write_data <= write_data;
    end
  end

  fme7_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_go),
    .item          (s1_item),
    .map_state     (map_state),
    .irq_flag_next (irq_flag_next)
  );

  // Address decode for lookups
  always_comb begin
    region_d = fme7_pkg::REGION_NONE;
    bank_d   = 8'd0;
    case (s1_item.func)
      fme7_pkg::FUNC_CPU: begin
        if (s1_item.address[15:13] == 3'b111) begin
          // last bank fixed
          region_d = fme7_pkg::REGION_PRG;
          bank_d   = prg_mask;
        end else if (s1_item.address[15]) begin
          region_d = fme7_pkg::REGION_PRG;
          case (s1_item.address[14:13])
            2'd0:    bank_d = map_state.prg_bank[0] & prg_mask;
            2'd1:    bank_d = map_state.prg_bank[1] & prg_mask;
            default: bank_d = map_state.prg_bank[2] & prg_mask;
          endcase
        end else if (s1_item.address[15:13] == 3'b011) begin
          if (map_state.ram_control[6]) begin
            region_d = map_state.ram_control[7] ? fme7_pkg::REGION_RAM_ON
                                                : fme7_pkg::REGION_RAM_OFF;
          end else begin
            region_d = fme7_pkg::REGION_PRG;
            bank_d   = map_state.ram_control & prg_mask;
          end
        end
      end
      fme7_pkg::FUNC_PPU: begin
        if (!s1_item.address[13]) begin
          region_d = fme7_pkg::REGION_CHR;
          bank_d   = map_state.chr_bank[s1_item.address[12:10]] & chr_mask;
        end else begin
          // nametable page by mirroring mode
          region_d = fme7_pkg::REGION_NT;
          if (map_state.mirror[1]) begin
            bank_d = {7'd0, map_state.mirror[0]};
          end else if (map_state.mirror[0]) begin
            bank_d = {7'd0, s1_item.address[11]};
          end else begin
            bank_d = {7'd0, s1_item.address[10]};
          end
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      region   <= region_d;
      bank     <= bank_d;
      irq_line <= irq_flag_next;
    end
  end

  // Input is only held off by a full pipe with a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without back-pressure");

  // An item leaving the input register shows up as a result
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid)
    else $error("result lost on advance");

  // Writes and ticks report no region
  a_no_region: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1_item.func == fme7_pkg::FUNC_WRITE || s1_item.func == fme7_pkg::FUNC_TICK)
    |=> region == fme7_pkg::REGION_NONE && bank == 8'd0)
    else $error("region reported for write or tick");

endmodule

// File: hw/rtl/fme7_regs.sv
// Mapper register file: command latch, bank registers and the IRQ down-counter.
module fme7_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  fme7_pkg::item_t     item,
  output fme7_pkg::map_state_t map_state,
  output logic                irq_flag_next
);

  logic [3:0]           command;
  logic [3:0]           command_next;
  fme7_pkg::map_state_t map_state_next;
  logic                 irq_enable;
  logic                 irq_enable_next;
  logic [15:0]          irq_counter;
  logic [15:0]          irq_counter_next;
  logic                 irq_flag;
  logic                 expire;

  assign expire = step && (item.func == fme7_pkg::FUNC_TICK) && irq_enable
                  && (irq_counter <= 16'd1);

  // Next state for one transaction
  always_comb begin
    command_next     = command;
    map_state_next   = map_state;
    irq_enable_next  = irq_enable;
    irq_counter_next = irq_counter;
    irq_flag_next    = irq_flag;
    if (step) begin
      case (item.func)
        fme7_pkg::FUNC_WRITE: begin
          // only 8000-BFFF is decoded
          if (item.address[15:14] == 2'b10) begin
            if (!item.address[13]) begin
              command_next = item.write_data[3:0];
            end else begin
              case (command)
                fme7_pkg::CMD_IRQ_EN: begin
                  irq_enable_next = |item.write_data;
                  if (~|item.write_data) irq_flag_next = 1'b0;
                end
                fme7_pkg::CMD_CNT_LO: irq_counter_next[7:0]  = item.write_data;
                fme7_pkg::CMD_CNT_HI: irq_counter_next[15:8] = item.write_data;
                fme7_pkg::CMD_MIRROR: map_state_next.mirror = item.write_data[1:0];
                fme7_pkg::CMD_PRG0:   map_state_next.prg_bank[0] = item.write_data;
                fme7_pkg::CMD_PRG1:   map_state_next.prg_bank[1] = item.write_data;
                fme7_pkg::CMD_PRG2:   map_state_next.prg_bank[2] = item.write_data;
                fme7_pkg::CMD_RAM_CTRL: map_state_next.ram_control = item.write_data;
                // commands 0-7 select a CHR slot
                default: map_state_next.chr_bank[command[2:0]] = item.write_data;
              endcase
            end
          end
        end
        fme7_pkg::FUNC_TICK: begin
          if (irq_enable) begin
            if (irq_counter <= 16'd1) begin
              irq_flag_next    = 1'b1;
              irq_enable_next  = 1'b0;
              irq_counter_next = fme7_pkg::IRQ_RELOAD;
            end else begin
              irq_counter_next = irq_counter - 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      command                 <= 4'd0;
      map_state.prg_bank      <= '0;
      map_state.chr_bank      <= '0;
      map_state.mirror        <= 2'd0;
      map_state.ram_control   <= fme7_pkg::RAM_CTRL_RESET;
      irq_enable              <= 1'b0;
      irq_counter             <= fme7_pkg::IRQ_RELOAD;
      irq_flag                <= 1'b0;
    end else begin
      command     <= command_next;
      map_state   <= map_state_next;
      irq_enable  <= irq_enable_next;
      irq_counter <= irq_counter_next;
      irq_flag    <= irq_flag_next;
    end
  end

  // Expiry disarms the counter, raises the flag and reloads
  a_expire: assert property (@(posedge clk) disable iff (rst)
    expire |=> !irq_enable && irq_flag && (irq_counter == fme7_pkg::IRQ_RELOAD))
    else $error("IRQ expiry not applied");

  // The flag only rises on a tick of an armed counter
  a_flag_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_flag) |-> $past(expire))
    else $error("IRQ flag raised without expiry");

  // Nothing changes without a transaction
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(irq_counter) && $stable(irq_enable) && $stable(command))
    else $error("state changed without a transaction");

endmodule

// File: dv/fme7_bank_mapper_with_irq_unit_tb.sv
// Self-checking testbench for the bank mapper with IRQ counter: directed table, then random traffic.
module fme7_bank_mapper_with_irq_unit_tb;

  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 500;

  // One result as the mapper reports it
  typedef struct packed {
    fme7_pkg::region_t region;
    logic [7:0]        bank;
    logic              irq;
  } mapping_t;

  // Per-transaction note: take the typed-in result instead of the predicted one
  typedef struct packed {
    logic     pinned;
    mapping_t want;
  } pin_t;

  // One row of the directed table
  typedef struct packed {
    fme7_pkg::func_t kind;
    logic [15:0]     addr;
    logic [7:0]      data;
    logic            pinned;
    mapping_t        want;
  } dir_row_t;

  logic            clk        = 1'b0;
  logic            rst        = 1'b1;
  logic            in_valid   = 1'b0;
  logic            in_stall;
  fme7_pkg::func_t func       = fme7_pkg::FUNC_WRITE;
  logic [15:0]     address    = '0;
  logic [7:0]      write_data = '0;
  logic            out_valid;
  logic            out_stall  = 1'b0;
  logic [2:0]      region;
  logic [7:0]      bank;
  logic            irq_line;
  logic            cfg_valid  = 1'b0;
  logic            cfg_ready;
  logic            cfg_index  = fme7_pkg::CFG_PRG_MASK;
  logic [7:0]      cfg_data   = '0;

  // Mapper state as predicted, at reset values
  logic [7:0]  prg_mask_q  = fme7_pkg::MASK_RESET;
  logic [7:0]  chr_mask_q  = fme7_pkg::MASK_RESET;
  logic [3:0]  cmd_q       = '0;
  logic [7:0]  prg_q [fme7_pkg::PRG_SLOTS] = '{default: 8'h00};
  logic [7:0]  chr_q [fme7_pkg::CHR_SLOTS] = '{default: 8'h00};
  logic [1:0]  mirror_q    = '0;
  logic [7:0]  ram_ctrl_q  = fme7_pkg::RAM_CTRL_RESET;
  logic        irq_en_q    = 1'b0;
  logic [15:0] irq_cnt_q   = fme7_pkg::IRQ_RELOAD;
  logic        irq_flag_q  = 1'b0;

  mapping_t expected_maps [$];
  pin_t     pin_notes [$];
  int       errors       = 0;
  int       quiet_cycles = 0;
  int       tx_idle_pct  = 0;
  int       rx_idle_pct  = 0;
  int       hold_reqs    = 0;
  int       holds_taken  = 0;
  int       hold_left    = 0;
  int       phase_items  = 0;

  // Reset state, extremes of the fields, every operation, IRQ arm and fire
  dir_row_t directed_rows [25] = '{
    '{fme7_pkg::FUNC_CPU, 16'h0000, 8'h00, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_CPU, 16'h5fff, 8'hff, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_CPU, 16'h6000, 8'h00, 1'b1, '{fme7_pkg::REGION_RAM_OFF, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_CPU, 16'hffff, 8'h00, 1'b1, '{fme7_pkg::REGION_PRG, 8'hff, 1'b0}},
    '{fme7_pkg::FUNC_CPU, 16'he000, 8'h00, 1'b1, '{fme7_pkg::REGION_PRG, 8'hff, 1'b0}},
    '{fme7_pkg::FUNC_CPU, 16'h8000, 8'h00, 1'b1, '{fme7_pkg::REGION_PRG, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_PPU, 16'h0000, 8'h00, 1'b1, '{fme7_pkg::REGION_CHR, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_PPU, 16'h2000, 8'h00, 1'b1, '{fme7_pkg::REGION_NT, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_PPU, 16'h2400, 8'h00, 1'b1, '{fme7_pkg::REGION_NT, 8'h01, 1'b0}},
    '{fme7_pkg::FUNC_PPU, 16'hffff, 8'h00, 1'b1, '{fme7_pkg::REGION_NT, 8'h01, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'h8000, {4'hf, fme7_pkg::CMD_CNT_LO}, 1'b1,
      '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'ha000, 8'h02, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'h9fff, {4'hf, fme7_pkg::CMD_CNT_HI}, 1'b1,
      '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'hbfff, 8'h00, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'h8000, {4'h0, fme7_pkg::CMD_IRQ_EN}, 1'b1,
      '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'ha000, 8'h01, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_TICK, 16'hffff, 8'hff, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_TICK, 16'h0000, 8'h00, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b1}},
    '{fme7_pkg::FUNC_TICK, 16'h0000, 8'h00, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b1}},
    '{fme7_pkg::FUNC_WRITE, 16'h7fff, {4'h0, fme7_pkg::CMD_IRQ_EN}, 1'b1,
      '{fme7_pkg::REGION_NONE, 8'h00, 1'b1}},
    '{fme7_pkg::FUNC_WRITE, 16'hc000, 8'h00, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b1}},
    '{fme7_pkg::FUNC_WRITE, 16'ha000, 8'h00, 1'b1, '{fme7_pkg::REGION_NONE, 8'h00, 1'b0}},
    '{fme7_pkg::FUNC_WRITE, 16'h8000, {4'h0, fme7_pkg::CMD_MIRROR}, 1'b0, '0},
    '{fme7_pkg::FUNC_WRITE, 16'ha000, 8'hff, 1'b0, '0},
    '{fme7_pkg::FUNC_PPU, 16'h2000, 8'h00, 1'b0, '0}
  };

  fme7_bank_mapper_with_irq_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .region     (region),
    .bank       (bank),
    .irq_line   (irq_line),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one transaction to the predicted state and returns the mapping it reports
  function automatic mapping_t mapper_step(fme7_pkg::func_t kind, logic [15:0] a,
                                           logic [7:0] d);
    mapping_t r;
    r = '0;
    case (kind)
      fme7_pkg::FUNC_WRITE: begin
        // only 8000-BFFF matters: low half latches the command, high half loads
        if (a[15:14] == 2'b10) begin
          if (!a[13]) begin
            cmd_q = d[3:0];
          end else begin
            case (cmd_q)
              fme7_pkg::CMD_IRQ_EN: begin
                irq_en_q = (d != 8'h00);
                if (d == 8'h00) irq_flag_q = 1'b0;
              end
              fme7_pkg::CMD_CNT_LO:   irq_cnt_q[7:0]  = d;
              fme7_pkg::CMD_CNT_HI:   irq_cnt_q[15:8] = d;
              fme7_pkg::CMD_MIRROR:   mirror_q = d[1:0];
              fme7_pkg::CMD_PRG0, fme7_pkg::CMD_PRG1, fme7_pkg::CMD_PRG2:
                prg_q[2'(cmd_q - fme7_pkg::CMD_PRG0)] = d;
              fme7_pkg::CMD_RAM_CTRL: ram_ctrl_q = d;
              default:                chr_q[cmd_q[2:0]] = d;
            endcase
          end
        end
      end
      fme7_pkg::FUNC_TICK: begin
        // counter exhausted at one or zero: flag, disarm, reload
        if (irq_en_q) begin
          if (irq_cnt_q <= 16'd1) begin
            irq_flag_q = 1'b1;
            irq_en_q   = 1'b0;
            irq_cnt_q  = fme7_pkg::IRQ_RELOAD;
          end else begin
            irq_cnt_q = irq_cnt_q - 16'd1;
          end
        end
      end
      fme7_pkg::FUNC_CPU: begin
        if (a >= 16'he000) begin
          r.region = fme7_pkg::REGION_PRG;
          r.bank   = prg_mask_q;
        end else if (a[15]) begin
          r.region = fme7_pkg::REGION_PRG;
          r.bank   = prg_q[a[14:13]] & prg_mask_q;
        end else if (a >= 16'h6000) begin
          // bit 6 selects work RAM, bit 7 enables it
          if (ram_ctrl_q[6]) begin
            r.region = ram_ctrl_q[7] ? fme7_pkg::REGION_RAM_ON : fme7_pkg::REGION_RAM_OFF;
          end else begin
            r.region = fme7_pkg::REGION_PRG;
            r.bank   = ram_ctrl_q & prg_mask_q;
          end
        end
      end
      default: begin
        // PPU: 14-bit decode, upper half is nametable space incl. palette
        if (!a[13]) begin
          r.region = fme7_pkg::REGION_CHR;
          r.bank   = chr_q[a[12:10]] & chr_mask_q;
        end else begin
          r.region = fme7_pkg::REGION_NT;
          if (mirror_q[1])      r.bank = {7'd0, mirror_q[0]};
          else if (mirror_q[0]) r.bank = {7'd0, a[11]};
          else                  r.bank = {7'd0, a[10]};
        end
      end
    endcase
    r.irq = irq_flag_q;
    return r;
  endfunction

  task automatic report_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Scoreboard: predict on each accepted input, compare on each accepted result
  always @(posedge clk) begin
    mapping_t want;
    pin_t     pin;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fme7_pkg::CFG_PRG_MASK) prg_mask_q = cfg_data;
        else                                     chr_mask_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        want = mapper_step(func, address, write_data);
        pin  = pin_notes.pop_front();
        if (pin.pinned) want = pin.want;
        expected_maps.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_maps.size() == 0) begin
          $display("%0t: unexpected result region %0d bank %0d irq %0d",
                   $time, region, bank, irq_line);
          errors++;
        end else begin
          want = expected_maps.pop_front();
          report_field("region", want.region, region);
          report_field("bank", want.bank, bank);
          report_field("irq_line", want.irq, irq_line);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_reqs != holds_taken) begin
      holds_taken = hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_item(fme7_pkg::func_t kind, logic [15:0] a, logic [7:0] d,
                           logic pinned, mapping_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pin_notes.push_back({pinned, want});
    in_valid   <= 1'b1;
    func       <= kind;
    address    <= a;
    write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_items++;
  endtask

  task automatic issue(fme7_pkg::func_t kind, logic [15:0] a, logic [7:0] d);
    send_item(kind, a, d, 1'b0, '0);
  endtask

  // Command write then data write, each at a random address in its window
  task automatic program_reg(logic [3:0] cmd, logic [7:0] d);
    issue(fme7_pkg::FUNC_WRITE, 16'h8000 | 16'($urandom_range(16'h1fff)),
          {4'($urandom), cmd});
    issue(fme7_pkg::FUNC_WRITE, 16'ha000 | 16'($urandom_range(16'h1fff)), d);
  endtask

  task automatic random_burst();
    int         pick;
    int         ticks;
    logic [3:0] cmd;
    logic [7:0] d;
    pick = $urandom_range(99);
    if (pick < 25) begin
      cmd = 4'($urandom);
      d   = 8'($urandom);
      if (cmd == fme7_pkg::CMD_CNT_HI && $urandom_range(3) != 0) d = 8'h00;
      program_reg(cmd, d);
    end else if (pick < 40) begin
      // arm a short count, then send ticks with lookups mixed in
      program_reg(fme7_pkg::CMD_CNT_LO, 8'($urandom_range(24)));
      program_reg(fme7_pkg::CMD_CNT_HI, ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00);
      program_reg(fme7_pkg::CMD_IRQ_EN,
                  ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      ticks = $urandom_range(30);
      repeat (ticks) begin
        if ($urandom_range(3) != 0)
          issue(fme7_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
        else
          issue(($urandom_range(1) != 0) ? fme7_pkg::FUNC_CPU : fme7_pkg::FUNC_PPU,
                16'($urandom), 8'($urandom));
      end
    end else if (pick < 60) begin
      issue(fme7_pkg::FUNC_CPU, 16'($urandom), 8'($urandom));
    end else if (pick < 80) begin
      issue(fme7_pkg::FUNC_PPU, 16'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      issue(fme7_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
    end else begin
      // stray write anywhere: ignored ranges, lone commands, lone data
      issue(fme7_pkg::FUNC_WRITE, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_maps.size() != 0) @(posedge clk);
  endtask

  task automatic set_masks(logic [7:0] prg_mask, logic [7:0] chr_mask);
    cfg_valid <= 1'b1;
    cfg_index <= fme7_pkg::CFG_PRG_MASK;
    cfg_data  <= prg_mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= fme7_pkg::CFG_CHR_MASK;
    cfg_data  <= chr_mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int tx_pct, int rx_pct, logic [7:0] prg_mask,
                              logic [7:0] chr_mask, bit with_hold);
    set_masks(prg_mask, chr_mask);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (with_hold) hold_reqs++;
    phase_items = 0;
    while (phase_items < ITEMS_PER_PHASE) random_burst();
    wait_drained();
  endtask

  // Main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].pinned, directed_rows[i].want);
    wait_drained();

    random_phase(17, 77, 8'h0f, 8'h3f, 1'b0);
    random_phase(77, 17, 8'h00, 8'hff, 1'b0);
    random_phase(0, 0, 8'hff, 8'h00, 1'b1);

    repeat (4) @(posedge clk);
    if (expected_maps.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_maps.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: fme7_bank_mapper_with_irq_unit.f
hw/rtl/fme7_pkg.sv
hw/rtl/fme7_regs.sv
hw/rtl/fme7_bank_mapper_with_irq_unit.sv
dv/fme7_bank_mapper_with_irq_unit_tb.sv
